@@ hdl/eccm_pkg.sv @@
// Shared types, constants and the colour palette of the escape-count colour mapper.
package eccm_pkg;

    localparam int CNT_W = 16;
    localparam int PIX_W = 8;
    localparam int QUO_W = 8;
    localparam int NUM_W = CNT_W + QUO_W;
    localparam int RAD_W = 2 * CNT_W;
    localparam int COLOURED = 14;

    localparam int DEF_COUNT_BITS = 16;
    localparam int DEF_PALETTE_SIZE = 15;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_GREY   = 2'd1,
        MODE_SQRT   = 2'd2,
        MODE_LINEAR = 2'd3
    } t_mode;

    typedef enum logic {
        REG_MODE = 1'b0,
        REG_MAX  = 1'b1
    } t_reg;

    localparam logic [3*PIX_W-1:0] PALETTE [COLOURED] = '{
        24'hFFFFFF, 24'hFF0000, 24'hFF8000, 24'hFFFF00,
        24'h80FF00, 24'h00FF00, 24'h00FF80, 24'h00FFFF,
        24'h0080FF, 24'h0000FF, 24'h8000E1, 24'hFF00FF,
        24'hFF0080, 24'h808080
    };

    // Entries past the coloured part of the palette are black.
    function automatic logic [3*PIX_W-1:0] palette_colour(input logic [QUO_W-1:0] idx);
        logic [3*PIX_W-1:0] c;
        c = '0;
        if (idx < QUO_W'(COLOURED)) begin
            c = PALETTE[idx[3:0]];
        end
        return c;
    endfunction

    // Item state along the square-root chain.
    typedef struct packed {
        logic              valid;
        t_mode             mode;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  maxc;
        logic [CNT_W-1:0]  divisor;
        logic [NUM_W-1:0]  grey_num;
        logic [CNT_W-1:0]  grey_den;
        logic [RAD_W-1:0]  rem;
        logic [CNT_W-1:0]  root;
    } t_sq_item;

    // Item state along the division chain.
    typedef struct packed {
        logic              valid;
        t_mode             mode;
        logic              black;
        logic              ovf;
        logic [NUM_W-1:0]  rem;
        logic [CNT_W-1:0]  den;
        logic [QUO_W-1:0]  quo;
    } t_dv_item;

endpackage

@@ hdl/escape_count_colour_map_top.sv @@
// Top level of the escape-count colour mapper: config registers, pipeline and output stage.
//
// Usage: pulse start with an escape count; the block never raises busy, so
// one count can be taken on every clock. Each count turns into one RGB
// triple on o_pixel_red/green/blue, marked by o_strobe for one cycle; the
// receiver takes it at the edge that ends that cycle and cannot stall it.
// Each count passes in order through the front stages, one square-root
// cell per count bit, stage 3, one division cell per quotient bit and the
// output register. Throughput: one pixel per cycle; the chain of cells is
// fully pipelined, every cell advances every cycle.
// Configuration: a valid/ready write channel, always ready; index 0 is the
// colour mode, index 1 the iteration limit. Write it only while no
// transaction is in flight. Reset sets mode greyscale and limit 255, and
// drops every item in the pipeline.
module escape_count_colour_map_top
    import eccm_pkg::*;
#(
    parameter int COUNT_BITS   = DEF_COUNT_BITS,
    parameter int PALETTE_SIZE = DEF_PALETTE_SIZE
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [CNT_W-1:0] i_escape_count,
    output logic             o_strobe,
    output logic [PIX_W-1:0] o_pixel_red,
    output logic [PIX_W-1:0] o_pixel_green,
    output logic [PIX_W-1:0] o_pixel_blue,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_addr,
    input  logic [CNT_W-1:0] i_cfg_data
);

    localparam int EFF_BITS = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;
    localparam logic [CNT_W-1:0] CNT_MASK = CNT_W'((64'd1 << EFF_BITS) - 64'd1);
    // Palette step is limit / (PALETTE_SIZE - 1), done as a multiply by reciprocal
    localparam int DIV_K    = PALETTE_SIZE - 1;
    localparam int RECIP_SH = CNT_W + $clog2(DIV_K);
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(DIV_K) - 64'd1) / 64'(DIV_K));
    localparam logic [QUO_W-1:0] IDX_MAX = QUO_W'(PALETTE_SIZE - 2);

    // Configuration registers
    t_mode            r_mode;
    logic [CNT_W-1:0] r_max_count;

    // Front stages
    logic                     r_s0_valid;
    t_mode                    r_s0_mode;
    logic [CNT_W-1:0]         r_s0_count;
    logic [CNT_W-1:0]         r_s0_maxc;
    logic                     r_s1_valid;
    t_mode                    r_s1_mode;
    logic [CNT_W-1:0]         r_s1_count;
    logic [CNT_W-1:0]         r_s1_maxc;
    logic [RAD_W-1:0]         r_s1_prod;
    logic [CNT_W+RECIP_W-1:0] r_s1_dprod;

    t_sq_item         n_s2;
    t_sq_item         r_s2;
    t_sq_item         sq_chain [CNT_W+1];
    t_dv_item         n_s3;
    t_dv_item         r_s3;
    t_dv_item         dv_chain [QUO_W+1];

    logic [CNT_W-1:0] m_val;
    logic [CNT_W-1:0] m_diff;
    logic [CNT_W-1:0] step;
    logic [CNT_W-1:0] sel_val;
    logic [QUO_W-1:0] idx;
    t_dv_item         last;

    logic             n_strobe;
    logic [PIX_W-1:0] n_red;
    logic [PIX_W-1:0] n_green;
    logic [PIX_W-1:0] n_blue;
    logic             r_strobe;
    logic [PIX_W-1:0] r_red;
    logic [PIX_W-1:0] r_green;
    logic [PIX_W-1:0] r_blue;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Config write: take every transaction, whatever the index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_GREY;
            r_max_count <= CNT_W'(255);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg'(i_cfg_addr))
                REG_MODE: r_mode      <= t_mode'(i_cfg_data[1:0]);
                REG_MAX:  r_max_count <= i_cfg_data;
                default:  r_mode      <= r_mode;
            endcase
        end
    end

    // Stage 0: capture the count and a snapshot of the config
    always_ff @(posedge i_clk) begin
        r_s0_mode  <= r_mode;
        r_s0_count <= i_escape_count & CNT_MASK;
        r_s0_maxc  <= r_max_count & CNT_MASK;
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= start && !busy;
        end
    end

    // Stage 1: the two products, each registered on its own
    always_ff @(posedge i_clk) begin
        r_s1_mode  <= r_s0_mode;
        r_s1_count <= r_s0_count;
        r_s1_maxc  <= r_s0_maxc;
        r_s1_prod  <= RAD_W'(r_s0_count) * RAD_W'(r_s0_maxc);
        r_s1_dprod <= (CNT_W+RECIP_W)'(r_s0_maxc) * (CNT_W+RECIP_W)'(RECIP);
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_s0_valid;
        end
    end

    // Stage 2: palette step, greyscale numerator and divisor, seed the root
    always_comb begin
        step   = CNT_W'(r_s1_dprod >> RECIP_SH);
        m_val  = (r_s1_maxc == '0) ? CNT_W'(1) : r_s1_maxc;
        m_diff = m_val - r_s1_count;

        n_s2.valid    = r_s1_valid;
        n_s2.mode     = r_s1_mode;
        n_s2.count    = r_s1_count;
        n_s2.maxc     = r_s1_maxc;
        n_s2.divisor  = (step == '0) ? CNT_W'(1) : step;
        n_s2.grey_den = m_val;
        n_s2.rem      = r_s1_prod;
        n_s2.root     = '0;
        // 255 * (m - count), zero once the count reaches the limit
        if (r_s1_count < m_val) begin
            n_s2.grey_num = (NUM_W'(m_diff) << PIX_W) - NUM_W'(m_diff);
        end else begin
            n_s2.grey_num = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= n_s2;
        end
    end

    // Square-root chain, most significant root bit first
    assign sq_chain[0] = r_s2;

    for (genvar gi = 0; gi < CNT_W; gi++) begin : g_sqrt
        eccm_sqrt_cell #(
            .BIT (CNT_W - 1 - gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_item  (sq_chain[gi]),
            .o_item  (sq_chain[gi+1])
        );
    end

    // Stage 3: pick the dividend and divisor for this mode
    always_comb begin
        sel_val = (sq_chain[CNT_W].mode == MODE_SQRT) ? sq_chain[CNT_W].root
                                                      : sq_chain[CNT_W].count;
        n_s3.valid = sq_chain[CNT_W].valid;
        n_s3.mode  = sq_chain[CNT_W].mode;
        n_s3.black = sel_val == sq_chain[CNT_W].maxc;
        n_s3.quo   = '0;
        if (sq_chain[CNT_W].mode == MODE_GREY) begin
            n_s3.rem = sq_chain[CNT_W].grey_num;
            n_s3.den = sq_chain[CNT_W].grey_den;
        end else begin
            n_s3.rem = NUM_W'(sel_val);
            n_s3.den = sq_chain[CNT_W].divisor;
        end
        // Quotient too large for the chain: palette index saturates
        n_s3.ovf = n_s3.rem >= {n_s3.den, QUO_W'(0)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3 <= '0;
        end else begin
            r_s3 <= n_s3;
        end
    end

    // Division chain, most significant quotient bit first
    assign dv_chain[0] = r_s3;

    for (genvar gj = 0; gj < QUO_W; gj++) begin : g_div
        eccm_div_cell #(
            .BIT (QUO_W - 1 - gj)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_item  (dv_chain[gj]),
            .o_item  (dv_chain[gj+1])
        );
    end

    // Output stage: greyscale, palette lookup or black
    assign last = dv_chain[QUO_W];

    always_comb begin
        if (last.ovf || last.quo > IDX_MAX) begin
            idx = IDX_MAX;
        end else begin
            idx = last.quo;
        end
        n_strobe = last.valid;
        unique case (last.mode)
            MODE_GREY: begin
                n_red   = last.quo;
                n_green = last.quo;
                n_blue  = last.quo;
            end
            MODE_SQRT, MODE_LINEAR: begin
                if (last.black) begin
                    {n_red, n_green, n_blue} = '0;
                end else begin
                    {n_red, n_green, n_blue} = palette_colour(idx);
                end
            end
            default: begin
                {n_red, n_green, n_blue} = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_pixel_red   = r_red;
    assign o_pixel_green = r_green;
    assign o_pixel_blue  = r_blue;

endmodule

@@ hdl/eccm_sqrt_cell.sv @@
// One square-root cell: settles one root bit and hands the item on.
module eccm_sqrt_cell
    import eccm_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_sq_item i_item,
    output t_sq_item o_item
);

    logic [RAD_W:0] trial;
    logic           fits;
    t_sq_item       n_item;
    t_sq_item       r_item;

    // (root + 2^BIT)^2 - root^2
    assign trial = ((RAD_W+1)'(i_item.root) << (BIT + 1)) + ((RAD_W+1)'(1) << (2 * BIT));
    assign fits  = {1'b0, i_item.rem} >= trial;

    always_comb begin
        n_item = i_item;
        if (fits) begin
            n_item.rem  = i_item.rem - trial[RAD_W-1:0];
            n_item.root = i_item.root | (CNT_W'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item <= '0;
        end else begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

@@ hdl/eccm_div_cell.sv @@
// One restoring-division cell: settles one quotient bit and hands the item on.
module eccm_div_cell
    import eccm_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dv_item i_item,
    output t_dv_item o_item
);

    logic [NUM_W-1:0] sub;
    t_dv_item         n_item;
    t_dv_item         r_item;

    assign sub = NUM_W'(i_item.den) << BIT;

    always_comb begin
        n_item = i_item;
        if (i_item.rem >= sub) begin
            n_item.rem = i_item.rem - sub;
            n_item.quo = i_item.quo | (QUO_W'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item <= '0;
        end else begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

@@ test/testbench.sv @@
// Testbench for the escape-count colour mapper: predicts each pixel colour and checks it.
`timescale 1ns / 100ps

module testbench
    import eccm_pkg::*;
();

    localparam int LATENCY   = 28;
    localparam int LIMIT_CYC = 400000;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [CNT_W-1:0] i_escape_count;
    logic             o_strobe;
    logic [PIX_W-1:0] o_pixel_red;
    logic [PIX_W-1:0] o_pixel_green;
    logic [PIX_W-1:0] o_pixel_blue;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic             i_cfg_addr;
    logic [CNT_W-1:0] i_cfg_data;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb;

    // Shadow copy of the configuration registers.
    t_mode            cur_mode;
    logic [CNT_W-1:0] cur_max;

    t_rgb pending_colours[$];
    int   error_count;
    int   pixel_count;
    int   cycle_count;

    escape_count_colour_map_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_escape_count (i_escape_count),
        .o_strobe       (o_strobe),
        .o_pixel_red    (o_pixel_red),
        .o_pixel_green  (o_pixel_green),
        .o_pixel_blue   (o_pixel_blue),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bit-serial integer square root, floor.
    function automatic logic [CNT_W-1:0] floor_root(input logic [2*CNT_W-1:0] v);
        logic [2*CNT_W-1:0] rem;
        logic [2*CNT_W-1:0] root;
        logic [2*CNT_W-1:0] bitv;
        rem  = v;
        root = '0;
        bitv = 32'h4000_0000;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[CNT_W-1:0];
    endfunction

    // Colour of one pixel under the current mode and limit.
    function automatic t_rgb pixel_colour(input logic [CNT_W-1:0] cnt);
        t_rgb             c;
        logic [31:0]      m;
        logic [31:0]      num;
        logic [31:0]      grey;
        logic [31:0]      div;
        logic [31:0]      idx;
        logic [CNT_W-1:0] n;
        logic [23:0]      tbl [COLOURED];
        tbl = '{24'hFFFFFF, 24'hFF0000, 24'hFF8000, 24'hFFFF00, 24'h80FF00, 24'h00FF00,
                24'h00FF80, 24'h00FFFF, 24'h0080FF, 24'h0000FF, 24'h8000E1, 24'hFF00FF,
                24'hFF0080, 24'h808080};
        c = '0;
        m = (cur_max < 1) ? 32'd1 : 32'(cur_max);
        n = cnt;
        if (cur_mode == MODE_GREY) begin
            grey = 0;
            if (32'(cnt) < m) begin
                num  = 255 * (m - 32'(cnt));
                grey = num / m;
            end
            c = {grey[7:0], grey[7:0], grey[7:0]};
        end else if (cur_mode == MODE_SQRT || cur_mode == MODE_LINEAR) begin
            if (cur_mode == MODE_SQRT) n = floor_root(32'(cnt) * 32'(cur_max));
            if (n != cur_max) begin
                div = 32'(cur_max) / 14;
                if (div < 1) div = 1;
                idx = 32'(n) / div;
                if (idx > 13) idx = 13;
                c = tbl[idx];
            end
        end
        return c;
    endfunction

    // Wait for the config channel, then write one register; the caller drops valid.
    task automatic write_reg(input t_reg idx, input logic [CNT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_MODE) cur_mode = t_mode'(val[1:0]);
        else cur_max = val;
    endtask

    // Send one escape count; queue the expected colour once accepted.
    // Hold start high afterwards; drop it before any gap.
    task automatic send_count(input logic [CNT_W-1:0] cnt);
        start          <= 1'b1;
        i_escape_count <= cnt;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_colours.push_back(pixel_colour(cnt));
        pixel_count++;
    endtask

    // Drain the pipeline so the registers may be rewritten.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_colours.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic configure(input t_mode md, input logic [CNT_W-1:0] mx);
        wait_idle();
        write_reg(REG_MODE, CNT_W'(md));
        write_reg(REG_MAX, mx);
        i_cfg_valid <= 1'b0;
    endtask

    // Counts biased toward the interesting edges of the current limit.
    function automatic logic [CNT_W-1:0] pick_count();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return cur_max;
        if (sel == 1) return CNT_W'($urandom_range(0, 3));
        if (sel == 2) return CNT_W'($urandom);
        if (sel == 3) return cur_max + CNT_W'($urandom_range(1, 3));
        if (sel == 4) return cur_max - CNT_W'($urandom_range(1, 3));
        return CNT_W'($urandom_range(0, cur_max));
    endfunction

    // Random bursts, random gaps; an occasional full drain in between.
    task automatic send_burst(input int n);
        int left;
        int burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left) burst = left;
            repeat (burst) send_count(pick_count());
            left -= burst;
            if ($urandom_range(0, 3) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            if ($urandom_range(0, 30) == 0) wait_idle();
        end
    endtask

    // Reset values, then edges of the count field in each mode.
    task automatic test_directed();
        send_count(16'd0);
        send_count(16'd255);
        send_count(16'd128);
        send_count(16'hFFFF);
        configure(MODE_LINEAR, 16'd140);
        send_count(16'd0);
        send_count(16'd9);
        send_count(16'd10);
        send_count(16'd139);
        send_count(16'd140);
        send_count(16'd141);
        send_count(16'hFFFF);
        configure(MODE_SQRT, 16'd2);
        send_count(16'd0);
        send_count(16'd1);
        send_count(16'd2);
        send_count(16'd3);
        configure(MODE_OFF, 16'd1000);
        send_count(16'd5);
        send_count(16'hAAAA);
        configure(MODE_GREY, 16'hFFFF);
        send_count(16'd0);
        send_count(16'd1);
        send_count(16'hFFFE);
        send_count(16'hFFFF);
        configure(MODE_GREY, 16'd0);
        send_count(16'd0);
        send_count(16'd1);
    endtask

    // Random counts over a spread of modes and limits, extremes included.
    task automatic test_random();
        logic [CNT_W-1:0] limits [8];
        limits = '{16'd2, 16'd13, 16'd14, 16'd255, 16'd1000, 16'h5555, 16'hAAAA, 16'hFFFF};
        for (int i = 0; i < 32; i++) begin
            configure(t_mode'(i < 28 ? 1 + (i % 3) : 0),
                      (i < 8) ? limits[i] : CNT_W'($urandom_range(2, 65535)));
            send_burst(i < 28 ? 44 : 10);
        end
    endtask

    // Check each strobed pixel against the oldest prediction.
    always @(posedge i_clk) begin
        t_rgb exp_c;
        if (i_rst_n && o_strobe) begin
            if (pending_colours.size() == 0) begin
                $error("pixel with no prediction waiting");
                error_count++;
            end else begin
                exp_c = pending_colours.pop_front();
                if (o_pixel_red !== exp_c.red) begin
                    $error("pixel_red expected %0d got %0d", exp_c.red, o_pixel_red);
                    error_count++;
                end
                if (o_pixel_green !== exp_c.green) begin
                    $error("pixel_green expected %0d got %0d", exp_c.green, o_pixel_green);
                    error_count++;
                end
                if (o_pixel_blue !== exp_c.blue) begin
                    $error("pixel_blue expected %0d got %0d", exp_c.blue, o_pixel_blue);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYC) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        error_count    = 0;
        pixel_count    = 0;
        cycle_count    = 0;
        cur_mode       = MODE_GREY;
        cur_max        = 16'd255;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_escape_count = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_addr     = REG_MODE;
        i_cfg_data     = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        wait_idle();
        $display("covered %0d pixels over all four modes, limits 0 to 65535", pixel_count);
        if (error_count == 0 && pending_colours.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ escape_count_colour_map_top.f @@
hdl/eccm_pkg.sv
hdl/eccm_sqrt_cell.sv
hdl/eccm_div_cell.sv
hdl/escape_count_colour_map_top.sv
test/testbench.sv
